>>> rtl/core/tbs_pkg.sv
// Types and constants shared by the TFTP block sender.
package tbs_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [15:0] ACK_OPCODE = 16'd4;
  localparam logic [3:0] RETRY_MAX = 4'd15;

  // event codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_ACK = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;
  localparam logic [1:0] REQ_RX_ERROR = 2'd3;

  // action codes
  localparam logic [2:0] ACT_SEND = 3'd0;
  localparam logic [2:0] ACT_RESEND = 3'd1;
  localparam logic [2:0] ACT_REJECT = 3'd2;
  localparam logic [2:0] ACT_DONE = 3'd3;
  localparam logic [2:0] ACT_GIVEUP = 3'd4;
  localparam logic [2:0] ACT_IGNORE = 3'd5;

  // session phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_GAVEUP = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSFER_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PEER_ADDRESS = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RETRY_LIMIT = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] source_address;
    logic [15:0] packet_opcode;
    logic [15:0] acked_block;
  } req_t;

  typedef struct packed {
    logic [2:0]             action;
    logic [15:0]            block_number;
    logic [LENGTH_BITS-1:0] data_offset;
    logic [15:0]            data_length;
  } rsp_t;

  typedef struct packed {
    logic [1:0]             phase;
    logic [15:0]            block_counter;
    logic [LENGTH_BITS-1:0] bytes_sent;
    logic [15:0]            last_length;
    logic [3:0]             retry_count;
  } sess_t;

  typedef struct packed {
    logic [15:0]            block_size;
    logic [LENGTH_BITS-1:0] transfer_length;
    logic [31:0]            peer_address;
    logic [3:0]             retry_limit;
  } cfg_t;

endpackage

>>> rtl/core/tftp_block_sender_core.sv
// Top level of the TFTP block sender: config registers, session state, result register.
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+--------------------------
//  in      | in_valid, in_ready, in_data      | sink      | tbs_pkg::req_t event
//  out     | out_valid, out_ready, out_data   | source    | tbs_pkg::rsp_t action
//  cfg     | cfg_valid, cfg_ready, cfg_index, | sink      | register index and value
//          | cfg_data                         |           |
//
//  One event per cycle unless out stalls; its result appears in the output register
//  the cycle after the transfer, set by the single registered pass through tbs_step.
//  Reset clears the session to idle and loads the register defaults.
//  in_ready is high whenever the result register is empty or being drained, so a
//  stalled output holds one result and blocks input only while it stays full.
//  cfg writes are always taken.
module tftp_block_sender_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tbs_pkg::req_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tbs_pkg::rsp_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tbs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import tbs_pkg::*;

  cfg_t  cfg;
  sess_t sess;
  sess_t sess_next;
  rsp_t  rsp_next;
  logic  in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size      <= 16'd512;
      cfg.transfer_length <= LENGTH_BITS'(1);
      cfg.peer_address    <= 32'd0;
      cfg.retry_limit     <= 4'd5;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE:      cfg.block_size      <= cfg_data[15:0];
        REG_TRANSFER_LENGTH: cfg.transfer_length <= cfg_data[LENGTH_BITS-1:0];
        REG_PEER_ADDRESS:    cfg.peer_address    <= cfg_data;
        REG_RETRY_LIMIT:     cfg.retry_limit     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  tbs_step u_step (
    .cfg       (cfg),
    .sess      (sess),
    .req       (in_data),
    .sess_next (sess_next),
    .rsp       (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sess      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        sess      <= sess_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data <= rsp_next;
    end
  end

endmodule

>>> rtl/core/tbs_step.sv
// Per-event session update: next session state and the resulting action.
module tbs_step (
  input  tbs_pkg::cfg_t  cfg,
  input  tbs_pkg::sess_t sess,
  input  tbs_pkg::req_t  req,
  output tbs_pkg::sess_t sess_next,
  output tbs_pkg::rsp_t  rsp
);
  import tbs_pkg::*;

  logic [15:0]            blk_base;
  logic [LENGTH_BITS-1:0] sent_base;
  logic [LENGTH_BITS-1:0] left;
  logic [15:0]            new_len;
  logic [3:0]             retry_bump;
  rsp_t                   send_rsp;
  sess_t                  send_sess;
  rsp_t                   resend_rsp;

  // a start event restarts from an empty session
  assign blk_base  = (req.req_type == REQ_START) ? 16'd0 : sess.block_counter;
  assign sent_base = (req.req_type == REQ_START) ? '0 : sess.bytes_sent;

  always_comb begin
    if (cfg.transfer_length > sent_base) begin
      left = cfg.transfer_length - sent_base;
    end else begin
      left = '0;
    end
    if (left < {{(LENGTH_BITS-16){1'b0}}, cfg.block_size}) begin
      new_len = left[15:0];
    end else begin
      new_len = cfg.block_size;
    end
  end

  always_comb begin
    send_sess.phase         = PH_WAIT;
    send_sess.block_counter = blk_base + 16'd1;
    send_sess.bytes_sent    = sent_base + {{(LENGTH_BITS-16){1'b0}}, new_len};
    send_sess.last_length   = new_len;
    send_sess.retry_count   = '0;
    send_rsp.action         = ACT_SEND;
    send_rsp.block_number   = blk_base + 16'd1;
    send_rsp.data_offset    = sent_base;
    send_rsp.data_length    = new_len;
  end

  always_comb begin
    resend_rsp.action       = ACT_RESEND;
    resend_rsp.block_number = sess.block_counter;
    resend_rsp.data_offset  = sess.bytes_sent
                              - {{(LENGTH_BITS-16){1'b0}}, sess.last_length};
    resend_rsp.data_length  = sess.last_length;
  end

  assign retry_bump = (sess.retry_count == RETRY_MAX) ? RETRY_MAX
                                                      : sess.retry_count + 4'd1;

  always_comb begin
    sess_next = sess;
    rsp       = '0;
    rsp.action = ACT_IGNORE;
    priority if (req.req_type == REQ_START) begin
      sess_next = send_sess;
      rsp       = send_rsp;
    end else if (sess.phase != PH_WAIT) begin
      rsp.action = ACT_IGNORE;
    end else if (req.req_type == REQ_ACK) begin
      priority if (req.source_address != cfg.peer_address) begin
        rsp        = resend_rsp;
        rsp.action = ACT_REJECT;
      end else if (req.packet_opcode != ACK_OPCODE
                   || req.acked_block != sess.block_counter) begin
        rsp = resend_rsp;
      end else if (sess.last_length < cfg.block_size) begin
        // short block acknowledged: transfer complete
        sess_next.phase = PH_DONE;
        rsp.action      = ACT_DONE;
      end else begin
        sess_next = send_sess;
        rsp       = send_rsp;
      end
    end else begin
      sess_next.retry_count = retry_bump;
      // limit is only enforced on timeouts, not on receive errors
      if (req.req_type == REQ_TIMEOUT && retry_bump >= cfg.retry_limit) begin
        sess_next.phase = PH_GAVEUP;
        rsp.action      = ACT_GIVEUP;
      end else begin
        rsp = resend_rsp;
      end
    end
  end

endmodule
